// File: rtl/core/sbpe_pkg.sv
// Shared types and constants for the screen byte pixel expander.
package sbpe_pkg;

    localparam logic [1:0] CFG_DISPLAY_START  = 2'd0;
    localparam logic [1:0] CFG_MEMORY_START   = 2'd1;
    localparam logic [1:0] CFG_CHARS_PER_ROW  = 2'd2;
    localparam logic [1:0] CFG_BITS_PER_PIXEL = 2'd3;

    localparam logic [1:0] BPP_1 = 2'd0;
    localparam logic [1:0] BPP_2 = 2'd1;
    localparam logic [1:0] BPP_4 = 2'd2;

    localparam logic [15:0] WRAP_BASE  = 16'h8000;
    localparam logic [6:0]  NARROW_CPR = 7'd80;

    localparam logic [14:0] DISPLAY_START_RST  = 15'h7C00;
    localparam logic [14:0] MEMORY_START_RST   = 15'h7C00;
    localparam logic [6:0]  CHARS_PER_ROW_RST  = 7'd80;
    localparam logic [1:0]  BITS_PER_PIXEL_RST = BPP_1;

    typedef struct packed {
        logic [14:0] display_start;
        logic [14:0] memory_start;
        logic [6:0]  chars_per_row;
        logic [1:0]  bits_per_pixel;
    } cfg_t;

    typedef struct packed {
        logic [9:0]  x_base;
        logic [15:0] ypos;
        logic [7:0]  data;
        logic [1:0]  bpp;
        logic        wide;
        logic        dup;
    } entry_t;

endpackage

// File: rtl/core/sbpe_front.sv
// Front end: accept an item, locate it on screen with a serial divider, hand it on.
module sbpe_front
    import sbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [14:0] address,
    input  logic [7:0]  data,
    input  cfg_t        cfg,
    input  logic        queue_full,
    output logic        busy,
    output logic        push,
    output entry_t      push_entry
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t      state_reg;
    logic [12:0] quo_reg;
    logic [6:0]  rem_reg;
    logic [2:0]  lo_reg;
    logic [3:0]  step_reg;
    logic [7:0]  data_reg;

    logic [15:0] off;
    logic [7:0]  partial;
    logic        q_bit;
    logic [7:0]  diff;
    logic [15:0] line;
    logic [15:0] ypos;
    logic        accept;
    logic        skip;

    always_comb
    begin
        if (address < cfg.display_start)
        begin
            off = {1'b0, address} + WRAP_BASE - {1'b0, cfg.memory_start}
                - {1'b0, cfg.display_start};
        end
        else
        begin
            off = {1'b0, address} - {1'b0, cfg.display_start};
        end
        skip    = (cfg.bits_per_pixel != BPP_1 && cfg.bits_per_pixel != BPP_2 &&
                   cfg.bits_per_pixel != BPP_4) ||
                  (cfg.chars_per_row == 7'd0);
        accept  = start && (state_reg == ST_IDLE);
        partial = {rem_reg, quo_reg[12]};
        q_bit   = (partial >= {1'b0, cfg.chars_per_row});
        diff    = partial - {1'b0, cfg.chars_per_row};
        line    = {quo_reg, lo_reg};
        ypos    = line + {2'b00, line[15:2]};
    end

    assign busy = (state_reg != ST_IDLE);
    assign push = (state_reg == ST_PUSH) && !queue_full;

    always_comb
    begin
        push_entry.x_base = {rem_reg, 3'b000};
        push_entry.ypos   = ypos;
        push_entry.data   = data_reg;
        push_entry.bpp    = cfg.bits_per_pixel;
        push_entry.wide   = (cfg.chars_per_row != NARROW_CPR);
        push_entry.dup    = (line[1:0] == 2'b00) && (line != 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !skip)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= 4'd12;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg - 4'd1;
                    if (step_reg == 4'd0)
                    begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!queue_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            quo_reg  <= off[15:3];
            lo_reg   <= off[2:0];
            rem_reg  <= '0;
            data_reg <= data;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[11:0], q_bit};
            rem_reg <= q_bit ? diff[6:0] : partial[6:0];
        end
    end

endmodule

// File: rtl/core/sbpe_queue.sv
// Two-entry queue between the front end and the pixel emitter.
module sbpe_queue
    import sbpe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   empty,
    output logic   full
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/sbpe_emit.sv
// Back end: walk the pixels of one queued item and drive them out one per cycle.
module sbpe_emit
    import sbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      entry,
    input  logic        empty,
    output logic        pop,
    output logic        strobe,
    output logic [10:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [3:0]  colour,
    output logic        last
);

    entry_t      cur_reg;
    logic        active_reg;
    logic [3:0]  idx_reg;
    logic        row_reg;
    logic        strobe_reg;
    logic [10:0] pixel_x_reg;
    logic [15:0] pixel_y_reg;
    logic [3:0]  colour_reg;
    logic        last_reg;

    logic        doubled;
    logic [3:0]  last_idx;
    logic        row_end;
    logic        final_pix;
    logic [10:0] xs;
    logic [2:0]  sel;
    logic [3:0]  col;
    logic        load;

    always_comb
    begin
        doubled   = (cur_reg.bpp != BPP_4) && cur_reg.wide;
        last_idx  = doubled ? 4'd15 : 4'd7;
        row_end   = (idx_reg == last_idx);
        final_pix = active_reg && row_end && (row_reg || !cur_reg.dup);
        xs        = doubled ? {cur_reg.x_base, 1'b0} : {1'b0, cur_reg.x_base};
        load      = (!active_reg || final_pix) && !empty;
        sel       = 3'd0;
        col       = 4'd0;
        case (cur_reg.bpp)
            BPP_1:
            begin
                sel = 3'd7 - (cur_reg.wide ? idx_reg[3:1] : idx_reg[2:0]);
                col = {cur_reg.data[sel], 3'b000};
            end
            BPP_2:
            begin
                sel = 3'd7 - {1'b0, (cur_reg.wide ? idx_reg[3:2] : idx_reg[2:1])};
                col = {cur_reg.data[sel], 1'b0, cur_reg.data[sel - 3'd4], 1'b0};
            end
            BPP_4:
            begin
                col = idx_reg[2]
                    ? {cur_reg.data[6], cur_reg.data[4], cur_reg.data[2], cur_reg.data[0]}
                    : {cur_reg.data[7], cur_reg.data[5], cur_reg.data[3], cur_reg.data[1]};
            end
            default:
            begin
                col = 4'd0;
            end
        endcase
    end

    assign pop     = load;
    assign strobe  = strobe_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign colour  = colour_reg;
    assign last    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
            row_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
                row_reg    <= 1'b0;
            end
            else if (final_pix)
            begin
                active_reg <= 1'b0;
            end
            else if (active_reg)
            begin
                if (row_end)
                begin
                    idx_reg <= '0;
                    row_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= entry;
        end
        if (active_reg)
        begin
            pixel_x_reg <= xs + {7'd0, idx_reg};
            pixel_y_reg <= cur_reg.ypos - {15'd0, row_reg};
            colour_reg  <= col;
            last_reg    <= final_pix;
        end
    end

endmodule

// File: rtl/core/screen_byte_pixel_expander.sv
// Screen byte pixel expander: turns one video memory byte write into its display pixels.
//
// A byte is taken when start is high and busy is low. The front end then goes through one
// load, 13 steps of a one-bit-per-cycle divider that splits the screen offset into character
// row and column, and one hand-off before busy drops again; the hand-off waits, and busy
// stays high, while the queue is full. Pixels leave one per cycle on strobe, 8, 16 or 32 per
// byte (a duplicate row doubles the count), with last marking the final one; the emitter
// reads from a two-entry queue, so the front end works on the next byte while pixels of
// earlier ones stream out. The receiver cannot stall strobe. Bytes written with
// chars_per_row zero or bits_per_pixel three produce no pixels.
module screen_byte_pixel_expander
    import sbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_enable,
    input  logic [1:0]  write_index,
    input  logic [14:0] write_data,
    input  logic        start,
    output logic        busy,
    input  logic [14:0] address,
    input  logic [7:0]  data,
    output logic        strobe,
    output logic [10:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [3:0]  colour,
    output logic        last
);

    cfg_t   cfg_reg;
    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t pop_entry;
    logic   empty;
    logic   full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_start  <= DISPLAY_START_RST;
            cfg_reg.memory_start   <= MEMORY_START_RST;
            cfg_reg.chars_per_row  <= CHARS_PER_ROW_RST;
            cfg_reg.bits_per_pixel <= BITS_PER_PIXEL_RST;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                CFG_DISPLAY_START:  cfg_reg.display_start  <= write_data;
                CFG_MEMORY_START:   cfg_reg.memory_start   <= write_data;
                CFG_CHARS_PER_ROW:  cfg_reg.chars_per_row  <= write_data[6:0];
                CFG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= write_data[1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    sbpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .address    (address),
        .data       (data),
        .cfg        (cfg_reg),
        .queue_full (full),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    sbpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty),
        .full       (full)
    );

    sbpe_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (pop_entry),
        .empty   (empty),
        .pop     (pop),
        .strobe  (strobe),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .colour  (colour),
        .last    (last)
    );

endmodule
